// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the scheduler checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MSQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define MSQ_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/msq_pkg.sv =====
// ---------------------------------------------------------------------------
// msq_pkg
// Shared types and constants of the multilevel queue scheduler
// ---------------------------------------------------------------------------
package msq_pkg;

  // fixed field widths
  localparam int CLOCK_W  = 20;
  localparam int PNUM_W   = 5;
  localparam int QUANT_W  = 16;
  localparam int LOAD_W   = 16;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd4;

  // input opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STEP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SPARE = 2'd3
  } opcode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_SLICE   = 3'd2,
    ST_DONE    = 3'd3,
    ST_NONE    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  // sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // search flags from the pending-bit unit
  typedef struct packed {
    logic ahead;   // high entry pending at or after the cursor
    logic any_hi;  // any high entry pending
    logic any_lo;  // any low entry pending
  } pick_t;

endpackage

// ===== src/msq_ram.sv =====
// ---------------------------------------------------------------------------
// msq_ram
// Generic single-port-write, single-port-read RAM with registered read data
// ---------------------------------------------------------------------------
module msq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/msq_pick.sv =====
// ---------------------------------------------------------------------------
// msq_pick
// Pending bits per slot and class, with find-first search for the scheduler
// ---------------------------------------------------------------------------
module msq_pick #(
  parameter int MAX_PROCS = 16,
  parameter int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  parameter int CNT_W     = $clog2(MAX_PROCS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CNT_W-1:0]     cursor,
  input  logic                 set_en,
  input  logic [IDX_W-1:0]     set_idx,
  input  logic                 set_hi,
  input  logic                 set_live,
  input  logic                 done_en,
  input  logic [IDX_W-1:0]     done_idx,
  input  logic                 clr_all,
  output msq_pkg::pick_t       flags,
  output logic [IDX_W-1:0]     ahead_idx,
  output logic [IDX_W-1:0]     hi_idx,
  output logic [IDX_W-1:0]     lo_idx
);

  import msq_pkg::*;

  logic [MAX_PROCS-1:0] pend_hi;
  logic [MAX_PROCS-1:0] pend_lo;
  logic [MAX_PROCS-1:0] ahead_vec;

  // pending bits: set on load, cleared on completion or table clear
  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      pend_hi <= '0;
      pend_lo <= '0;
    end else begin
      if (set_en) begin
        pend_hi[set_idx] <= set_hi & set_live;
        pend_lo[set_idx] <= ~set_hi & set_live;
      end
      if (done_en) begin
        pend_hi[done_idx] <= 1'b0;
        pend_lo[done_idx] <= 1'b0;
      end
    end
  end

  // high entries at or after the cursor
  always_comb begin
    for (int k = 0; k < MAX_PROCS; k++) begin
      ahead_vec[k] = pend_hi[k] && (CNT_W'(k) >= cursor);
    end
  end

  // priority encoders, lowest index wins
  always_comb begin
    ahead_idx = '0;
    hi_idx    = '0;
    lo_idx    = '0;
    for (int k = MAX_PROCS - 1; k >= 0; k--) begin
      if (ahead_vec[k]) ahead_idx = IDX_W'(k);
      if (pend_hi[k])   hi_idx    = IDX_W'(k);
      if (pend_lo[k])   lo_idx    = IDX_W'(k);
    end
  end

  assign flags.ahead  = |ahead_vec;
  assign flags.any_hi = |pend_hi;
  assign flags.any_lo = |pend_lo;

endmodule

// ===== src/multilevel_queue_scheduler.sv =====
// ---------------------------------------------------------------------------
// multilevel_queue_scheduler
// Process table with round robin high class and first-come low class
// ---------------------------------------------------------------------------
// Input stream s_*: tuser carries the opcode (load, step, clear), tdata the
// burst length and class of a load. Every accepted item yields exactly one
// result on the output stream m_*: tuser is the status, tdata the one-based
// process number, the queue used and the accumulated end time.
// A separate write port (cfg_wen, cfg_wdata) sets the quantum; write it only
// while no item is in flight.
// Sequence: an item is taken in the idle state; the execute state then runs it
// and loads the output register, and no new item is taken until that is
// done. This sequence comes from the remaining-time RAM: the slot chosen by
// the pending-bit search is read when the item is taken and written back
// when it executes.
// When the receiver stalls, the finished result waits in the output
// register and the execute cycle holds until it is taken.
// Reset empties the table, zeroes the time and restores a quantum of 4;
// the RAM needs no clearing pass, since read data is used only for loaded slots.
// ---------------------------------------------------------------------------
module multilevel_queue_scheduler #(
  parameter int MAX_PROCS  = 16,
  parameter int BURST_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: quantum
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] burst_length, [16] high_class, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [4:0] process_number, [5] queue_used, [25:6] end_time
  output logic [2:0]  m_tuser    // [2:0] status
);

  import msq_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int CMP_W = (BURST_BITS > QUANT_W) ? BURST_BITS : QUANT_W;
  localparam int EXT_W = (CMP_W > LOAD_W) ? CMP_W : LOAD_W;
  localparam int SUM_W = (CMP_W > CLOCK_W) ? CMP_W : CLOCK_W;

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   cursor;
  logic [CLOCK_W-1:0] clock_time;
  logic [QUANT_W-1:0] quantum;

  // item held between accept and execute
  logic               step_hit;
  logic               step_low;
  logic [IDX_W-1:0]   sel_idx;
  status_t            stage_status;
  logic [PNUM_W-1:0]  stage_pnum;
  logic               stage_queue;
  logic [CLOCK_W-1:0] stage_time;

  // output register
  status_t            out_status;
  logic [PNUM_W-1:0]  out_pnum;
  logic               out_queue;
  logic [CLOCK_W-1:0] out_time;

  // handshake and decode
  logic               accept;
  logic               commit;
  opcode_t            op;
  logic [LOAD_W-1:0]  in_burst;
  logic               in_hi;
  logic [EXT_W-1:0]   burst_ext;
  logic [BURST_BITS-1:0] burst_fit;
  logic               full;
  logic               do_load;

  // search result
  pick_t              flags;
  logic [IDX_W-1:0]   ahead_idx;
  logic [IDX_W-1:0]   hi_idx;
  logic [IDX_W-1:0]   lo_idx;
  logic               pick_hit;
  logic               pick_low;
  logic [IDX_W-1:0]   pick_idx;

  // execute datapath
  logic [BURST_BITS-1:0] ram_rdata;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [BURST_BITS-1:0] ram_wdata;
  logic [QUANT_W-1:0]    q_eff;
  logic [CMP_W-1:0]      r_ext;
  logic [CMP_W-1:0]      q_ext;
  logic                  finished;
  logic [CMP_W-1:0]      slice;
  logic [CMP_W-1:0]      r_left;
  logic [CLOCK_W-1:0]    clock_next;
  logic [IDX_W:0]        sel_num;

  assign op        = opcode_t'(s_tuser);
  assign in_burst  = s_tdata[LOAD_W-1:0];
  assign in_hi     = s_tdata[LOAD_W];
  assign burst_ext = EXT_W'(in_burst);
  assign burst_fit = burst_ext[BURST_BITS-1:0];
  assign full      = (entry_count == CNT_W'(MAX_PROCS));
  assign accept    = s_tvalid && s_tready;
  assign do_load   = accept && (op == OP_LOAD) && !full;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    commit   = 1'b0;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_EXEC: commit   = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pending-bit search unit
  msq_pick #(
    .MAX_PROCS (MAX_PROCS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .cursor    (cursor),
    .set_en    (do_load),
    .set_idx   (entry_count[IDX_W-1:0]),
    .set_hi    (in_hi),
    .set_live  (burst_fit != '0),
    .done_en   (commit && step_hit && finished),
    .done_idx  (sel_idx),
    .clr_all   (accept && (op == OP_CLEAR)),
    .flags     (flags),
    .ahead_idx (ahead_idx),
    .hi_idx    (hi_idx),
    .lo_idx    (lo_idx)
  );

  // choose the slot: ahead of cursor, else wrap to a new pass, else low class
  always_comb begin
    pick_hit = 1'b1;
    pick_low = 1'b0;
    pick_idx = ahead_idx;
    if (flags.ahead) begin
      pick_idx = ahead_idx;
    end else if (flags.any_hi) begin
      pick_idx = hi_idx;
    end else if (flags.any_lo) begin
      pick_idx = lo_idx;
      pick_low = 1'b1;
    end else begin
      pick_hit = 1'b0;
    end
  end

  // remaining-time memory
  always_comb begin
    if (state == S_IDLE) begin
      ram_we    = do_load;
      ram_waddr = entry_count[IDX_W-1:0];
      ram_wdata = burst_fit;
    end else begin
      ram_we    = commit && step_hit;
      ram_waddr = sel_idx;
      ram_wdata = r_left[BURST_BITS-1:0];
    end
  end

  msq_ram #(
    .WIDTH (BURST_BITS),
    .DEPTH (MAX_PROCS),
    .AW    (IDX_W)
  ) u_remaining (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && (op == OP_STEP)),
    .raddr (pick_idx),
    .rdata (ram_rdata)
  );

  // slice arithmetic on the read-back remaining time
  assign q_eff      = (quantum == '0) ? QUANT_W'(1) : quantum;
  assign r_ext      = CMP_W'(ram_rdata);
  assign q_ext      = CMP_W'(q_eff);
  assign finished   = step_low || (r_ext <= q_ext);
  assign slice      = finished ? r_ext : q_ext;
  assign r_left     = finished ? '0 : (r_ext - q_ext);
  assign clock_next = CLOCK_W'(SUM_W'(clock_time) + SUM_W'(slice));
  assign sel_num    = {1'b0, sel_idx} + (IDX_W + 1)'(1);

  // quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg_wen) begin
      quantum <= cfg_wdata;
    end
  end

  // table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      cursor      <= '0;
      clock_time  <= '0;
    end else if (accept) begin
      case (op)
        OP_LOAD: begin
          if (!full) entry_count <= entry_count + CNT_W'(1);
        end
        OP_STEP: begin
          if (pick_hit && !pick_low) begin
            cursor <= CNT_W'(pick_idx) + CNT_W'(1);
          end else begin
            cursor <= '0;
          end
        end
        OP_CLEAR: begin
          entry_count <= '0;
          cursor      <= '0;
          clock_time  <= '0;
        end
        default: ;
      endcase
    end else if (commit && step_hit) begin
      clock_time <= clock_next;
    end
  end

  // stage the item between accept and execute
  always_ff @(posedge clk) begin
    if (rst) begin
      step_hit <= 1'b0;
    end else if (accept) begin
      step_hit <= (op == OP_STEP) && pick_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_low     <= pick_low;
      sel_idx      <= pick_idx;
      stage_status <= ST_NONE;
      stage_pnum   <= '0;
      stage_queue  <= 1'b0;
      stage_time   <= clock_time;
      case (op)
        OP_LOAD: begin
          if (full) begin
            stage_status <= ST_FULL;
          end else begin
            stage_status <= ST_LOADED;
            stage_pnum   <= PNUM_W'(entry_count + CNT_W'(1));
            stage_queue  <= ~in_hi;
          end
        end
        OP_CLEAR: begin
          stage_status <= ST_CLEARED;
          stage_time   <= '0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (step_hit) begin
        out_status <= finished ? ST_DONE : ST_SLICE;
        out_pnum   <= PNUM_W'(sel_num);
        out_queue  <= step_low;
        out_time   <= clock_next;
      end else begin
        out_status <= stage_status;
        out_pnum   <= stage_pnum;
        out_queue  <= stage_queue;
        out_time   <= stage_time;
      end
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {6'd0, out_time, out_queue, out_pnum};

endmodule

// ===== src/msq_checker.sv =====
// ---------------------------------------------------------------------------
// msq_checker
// Port-level assertions for the multilevel queue scheduler, bound to the top
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser
);

  import msq_pkg::*;

  // a stalled result holds its payload
  `MSQ_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // one item in flight: no transfer in the cycle after a transfer
  `MSQ_ASSERT(a_one_in_flight, clk, rst, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

  // a clear reports all-zero fields
  `MSQ_ASSERT(a_clear_zero, clk, rst, m_tvalid && (m_tuser == ST_CLEARED) |-> (m_tdata == 32'd0), "clear result not zero")

  // rejected loads and idle steps name no process
  `MSQ_NEVER(a_none_pnum, clk, rst, m_tvalid && ((m_tuser == ST_NONE) || (m_tuser == ST_FULL)) && (m_tdata[4:0] != 5'd0), "process number on empty result")

endmodule

bind multilevel_queue_scheduler msq_checker u_msq_checker (.*);

// ===== dv/multilevel_queue_scheduler_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multilevel_queue_scheduler_test
// Self-checking testbench for the multilevel queue scheduler
// ---------------------------------------------------------------------------
// Loads, steps and clears are streamed into the block. Each accepted transfer
// is run through a local scheduler model that keeps its own process table,
// pass bookkeeping, clock and quantum, and the predicted event is queued.
// Every output transfer is compared field by field with the oldest queued
// event. A short directed part covers round robin slices, first-come low
// entries, zero bursts, a full table, the spare opcode, clear and quantum
// extremes; a long random part of load and drain sequences follows, with
// sender gaps, receiver stalls and one long output hold-off.
// ---------------------------------------------------------------------------
module multilevel_queue_scheduler_test;
  import msq_pkg::*;

  localparam int MAX_SLOTS = 16;

  typedef struct packed {
    status_t     status;
    logic [4:0]  proc_num;
    logic        queue_lo;
    logic [19:0] end_time;
  } sched_event_t;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [15:0] burst_length, [16] high_class, rest zero
  logic [1:0]  s_tuser;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [4:0] process_number, [5] queue_used, [25:6] end_time
  logic [2:0]  m_tuser;   // [2:0] status

  // scheduler model state
  logic [15:0] rem_time [MAX_SLOTS];
  logic        is_high  [MAX_SLOTS];
  int          n_loaded;
  int          pass_cursor;
  logic        pass_served_high;
  logic [19:0] now_time;
  logic [15:0] quantum_reg;

  sched_event_t predicted_events[$];
  sched_event_t oldest_event;
  int           fail_count;
  int           items_sent;
  int           burst_left;
  int           stall_cycles;

  multilevel_queue_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void record_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic void reset_model();
    n_loaded         = 0;
    pass_cursor      = 0;
    pass_served_high = 1'b0;
    now_time         = '0;
    quantum_reg      = QUANTUM_RESET;
  endfunction

  // first pending slot of a class at or after a start slot, n_loaded if none
  function automatic int first_pending(input int from, input logic want_high);
    for (int i = from; i < n_loaded; i++) begin
      if (is_high[i] == want_high && rem_time[i] != 0) return i;
    end
    return n_loaded;
  endfunction

  function automatic bit work_pending();
    return first_pending(0, 1'b1) < n_loaded || first_pending(0, 1'b0) < n_loaded;
  endfunction

  // advance the scheduler model by one item and return the event it causes
  function automatic sched_event_t predict_event(input opcode_t op, input logic [15:0] burst,
                                                 input logic hc);
    sched_event_t ev;
    int           slot;
    logic [15:0]  slice;
    ev = '{status: ST_NONE, proc_num: 5'd0, queue_lo: 1'b0, end_time: now_time};
    case (op)
      OP_LOAD: begin
        if (n_loaded >= MAX_SLOTS) begin
          ev.status = ST_FULL;
        end else begin
          rem_time[n_loaded] = burst;
          is_high[n_loaded]  = hc;
          n_loaded++;
          ev.status   = ST_LOADED;
          ev.proc_num = 5'(n_loaded);
          ev.queue_lo = !hc;
        end
      end
      OP_STEP: begin
        slot = first_pending(pass_cursor, 1'b1);
        // pass exhausted: restart from slot 0
        if (slot >= n_loaded && (pass_served_high || pass_cursor != 0)) begin
          pass_cursor      = 0;
          pass_served_high = 1'b0;
          slot             = first_pending(0, 1'b1);
        end
        if (slot < n_loaded) begin
          slice = (quantum_reg == 0) ? 16'd1 : quantum_reg;
          if (rem_time[slot] > slice) begin
            now_time       = now_time + 20'(slice);
            rem_time[slot] = rem_time[slot] - slice;
            ev.status      = ST_SLICE;
          end else begin
            now_time       = now_time + 20'(rem_time[slot]);
            rem_time[slot] = '0;
            ev.status      = ST_DONE;
          end
          pass_served_high = 1'b1;
          pass_cursor      = slot + 1;
          ev.proc_num      = 5'(slot + 1);
          ev.end_time      = now_time;
        end else begin
          // high queue idle for a whole pass: run the first low entry to the end
          slot = first_pending(0, 1'b0);
          if (slot < n_loaded) begin
            now_time         = now_time + 20'(rem_time[slot]);
            rem_time[slot]   = '0;
            pass_cursor      = 0;
            pass_served_high = 1'b0;
            ev.status        = ST_DONE;
            ev.proc_num      = 5'(slot + 1);
            ev.queue_lo      = 1'b1;
            ev.end_time      = now_time;
          end
        end
      end
      OP_CLEAR: begin
        n_loaded         = 0;
        pass_cursor      = 0;
        pass_served_high = 1'b0;
        now_time         = '0;
        ev.status        = ST_CLEARED;
        ev.end_time      = '0;
      end
      default: ;
    endcase
    return ev;
  endfunction

  // one input transfer, with random gaps between bursts
  task automatic send_item(input opcode_t op, input logic [15:0] burst, input logic hc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, hc, burst};
    do @(posedge clk); while (!s_tready);
    predicted_events.push_back(predict_event(op, burst, hc));
    items_sent++;
  endtask

  // opcode whose data fields are don't care
  task automatic send_op(input opcode_t op);
    send_item(op, 16'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (predicted_events.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [15:0] value);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen     <= 1'b0;
    quantum_reg = value;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_events.size() == 0) begin
        record_failure($sformatf("unexpected result: status %0d tdata %h", m_tuser, m_tdata));
      end else begin
        oldest_event = predicted_events.pop_front();
        if (m_tuser !== oldest_event.status || m_tdata[4:0] !== oldest_event.proc_num ||
            m_tdata[5] !== oldest_event.queue_lo || m_tdata[25:6] !== oldest_event.end_time)
          record_failure($sformatf(
            "mismatch exp/got: status %0d/%0d proc %0d/%0d queue %0d/%0d end_time %0d/%0d",
            oldest_event.status, m_tuser, oldest_event.proc_num, m_tdata[4:0],
            oldest_event.queue_lo, m_tdata[5], oldest_event.end_time, m_tdata[25:6]));
      end
    end
  end

  // receiver stall pattern, with a counted hold-off on request
  initial begin : rx_pattern
    int   mode;
    int   mode_left;
    int   run_left;
    logic run_level;
    mode      = 0;
    mode_left = 0;
    run_left  = 0;
    run_level = 1'b1;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        m_tready <= 1'b0;
        stall_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: begin
            if (run_left == 0) begin
              run_level = !run_level;
              run_left  = $urandom_range(1, 8);
            end
            run_left--;
            m_tready <= run_level;
          end
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // round robin slices, low entry after an idle pass, zero burst, spare, clear
  task automatic test_basic_schedule();
    send_item(OP_LOAD, 16'd10, 1'b1);
    send_item(OP_LOAD, 16'd5, 1'b0);
    send_item(OP_LOAD, 16'd0, 1'b1);
    repeat (5) send_op(OP_STEP);
    send_op(OP_SPARE);
    send_op(OP_CLEAR);
  endtask

  // fill every slot, then one load past capacity
  task automatic test_table_full();
    send_item(OP_LOAD, 16'hFFFF, 1'b1);
    send_item(OP_LOAD, 16'd0, 1'b0);
    for (int i = 2; i < MAX_SLOTS; i++) send_item(OP_LOAD, 16'($urandom), 1'(i));
    send_op(OP_LOAD);
  endtask

  // zero quantum acts as one, largest quantum finishes a max burst at once
  task automatic test_quantum_extremes();
    write_quantum(16'd0);
    send_op(OP_CLEAR);
    send_item(OP_LOAD, 16'd3, 1'b1);
    repeat (3) send_op(OP_STEP);
    write_quantum(16'hFFFF);
    send_item(OP_LOAD, 16'hFFFF, 1'b1);
    send_op(OP_STEP);
  endtask

  // long output hold-off while items keep coming, then a full pause
  task automatic test_output_stall();
    wait_drained();
    stall_cycles = 300;
    repeat (24) begin
      if ($urandom_range(0, 1) == 0) send_item(OP_LOAD, 16'($urandom_range(0, 40)), 1'($urandom));
      else send_op(OP_STEP);
    end
    wait_drained();
  endtask

  // full table of maximum bursts drained, end time near its top
  task automatic test_longest_run();
    write_quantum(16'hFFFF);
    send_op(OP_CLEAR);
    repeat (MAX_SLOTS) send_item(OP_LOAD, 16'hFFFF, 1'($urandom));
    while (work_pending()) send_op(OP_STEP);
    send_op(OP_STEP);
  endtask

  // random load and drain sequences under changing quanta
  task automatic test_random_mix(input int count);
    int          stop_at;
    int          steps;
    int unsigned burst_max;
    logic [15:0] q;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: q = 16'd0;
        1: q = 16'd1;
        2: q = 16'hFFFF;
        3: q = 16'($urandom);
        default: q = 16'($urandom_range(1, 16));
      endcase
      write_quantum(q);
      burst_max = ((q == 0) ? 1 : q) * $urandom_range(1, 4);
      if (burst_max > 65535 || $urandom_range(0, 7) == 0) burst_max = 65535;
      if ($urandom_range(0, 2) == 0) send_op(OP_CLEAR);
      // loads with occasional steps and noise mixed in
      repeat ($urandom_range(1, 18)) begin
        case ($urandom_range(0, 15))
          0, 1, 2: send_op(OP_STEP);
          3: send_op(OP_SPARE);
          4: send_item(OP_LOAD, 16'd0, 1'($urandom));
          default: send_item(OP_LOAD, 16'($urandom_range(0, burst_max)), 1'($urandom));
        endcase
      end
      // drain, bounded so long bursts with a short slice stay cheap
      steps = 0;
      while (work_pending() && steps < 60) begin
        send_op(OP_STEP);
        steps++;
      end
      repeat ($urandom_range(0, 2)) send_op(OP_STEP);
    end
  endtask

  initial begin : run_tests
    int drain_wait;
    rst        <= 1'b1;
    cfg_wen    <= 1'b0;
    cfg_wdata  <= '0;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= OP_LOAD;
    fail_count   = 0;
    items_sent   = 0;
    burst_left   = 0;
    stall_cycles = 0;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_schedule();
    test_table_full();
    test_quantum_extremes();
    test_output_stall();
    test_longest_run();
    test_random_mix(1150);

    // drain the last results
    s_tvalid <= 1'b0;
    drain_wait = 0;
    while (predicted_events.size() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (4) @(posedge clk);
    if (predicted_events.size() != 0)
      record_failure($sformatf("%0d results never arrived", predicted_events.size()));

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/msq_pkg.sv
src/msq_ram.sv
src/msq_pick.sv
src/multilevel_queue_scheduler.sv
src/msq_checker.sv
dv/multilevel_queue_scheduler_test.sv
